[src/tile_run_length_frame_decoder_core_macros.svh]
// Assertion macros for the tile run-length frame decoder checker.
// Expects clk and rst_n in scope at the point of use.
`ifndef TILE_RUN_LENGTH_FRAME_DECODER_CORE_MACROS_SVH
`define TILE_RUN_LENGTH_FRAME_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define TRLD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trld assertion failed");

// next-cycle implication
`define TRLD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trld assertion failed");

`endif

[src/trld_pkg.sv]
// Shared widths and constants for the tile run-length frame decoder.
// No dependencies.
`default_nettype none

package trld_pkg;

  localparam int unsigned IDX_W   = 11;  // tile index field
  localparam int unsigned RUN_W   = 16;  // run word
  localparam int unsigned CNT_W   = 5;   // repeat count in run word
  localparam int unsigned TILE_W  = 64;  // one dictionary tile
  localparam int unsigned LINE_W  = 8;   // one tile row
  localparam int unsigned POS_W   = 6;   // grid position, 8x8 cells
  localparam int unsigned AXIS_W  = 3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

endpackage

`default_nettype wire

[src/tile_run_length_frame_decoder_core.sv]
// Tile run-length frame decoder core.
// Input channel (in_*): a load request (in_operation = 0) writes in_tile_bits into the
// tile dictionary at in_tile_index; a run request (in_operation = 1) carries in_run_word,
// bits 15:5 the tile index and bits 4:0 the repeat count. A zero run word ends the frame.
// Output channel (out_*): one request per emitted tile, with grid row/column, the eight
// inverted row bytes, and out_last on the final tile of the run.
// A load, an end-of-frame word or a zero-count word never enters the emit state. For a
// run, the dictionary memory has a registered read, then one tile leaves per cycle
// while out_ready is high, until the repeat count is used up.
// The block handles one request at a time; in_ready is low while tiles are emitted.
// A stalled receiver holds the current tile and its payload stable until taken.
// Reset clears the grid position and the control state at once; the dictionary has no
// reset and needs no clearing pass; an entry must be loaded before a run reads it.
// Run indexes at or beyond DICT_DEPTH read an all-zero tile (all line bytes 0xFF).
// Depends on trld_pkg.
`default_nettype none

module tile_run_length_frame_decoder_core #(
  parameter int unsigned DICT_DEPTH = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_operation,
  input  wire logic [trld_pkg::IDX_W-1:0]    in_tile_index,
  input  wire logic [trld_pkg::TILE_W-1:0]   in_tile_bits,
  input  wire logic [trld_pkg::RUN_W-1:0]    in_run_word,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [trld_pkg::AXIS_W-1:0]        out_grid_row,
  output logic [trld_pkg::AXIS_W-1:0]        out_grid_col,
  output logic [trld_pkg::LINE_W-1:0]        out_line0,
  output logic [trld_pkg::LINE_W-1:0]        out_line1,
  output logic [trld_pkg::LINE_W-1:0]        out_line2,
  output logic [trld_pkg::LINE_W-1:0]        out_line3,
  output logic [trld_pkg::LINE_W-1:0]        out_line4,
  output logic [trld_pkg::LINE_W-1:0]        out_line5,
  output logic [trld_pkg::LINE_W-1:0]        out_line6,
  output logic [trld_pkg::LINE_W-1:0]        out_line7,
  output logic                               out_last
);

  localparam int unsigned AW = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
  localparam logic [trld_pkg::IDX_W:0] DEPTH_L = (trld_pkg::IDX_W + 1)'(DICT_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t                          state_r;
  logic [trld_pkg::POS_W-1:0]      pos_r;
  logic [trld_pkg::CNT_W-1:0]      cnt_r;
  logic                            oor_r;
  logic                            out_valid_r;
  logic [trld_pkg::TILE_W-1:0]     rd_data_r;
  logic [trld_pkg::TILE_W-1:0]     tile_mem [DICT_DEPTH];

  logic                            in_fire;
  logic                            out_fire;
  logic [trld_pkg::IDX_W-1:0]      run_idx;
  logic [trld_pkg::CNT_W-1:0]      run_cnt;
  logic                            load_ok;
  logic                            run_oor;
  logic [trld_pkg::TILE_W-1:0]     tile_q;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  assign run_idx = in_run_word[trld_pkg::RUN_W-1:trld_pkg::CNT_W];
  assign run_cnt = in_run_word[trld_pkg::CNT_W-1:0];
  assign load_ok = {1'b0, in_tile_index} < DEPTH_L;
  assign run_oor = !({1'b0, run_idx} < DEPTH_L);

  // dictionary: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_fire && (in_operation == trld_pkg::OP_LOAD) && load_ok) begin
      tile_mem[in_tile_index[AW-1:0]] <= in_tile_bits;
    end
    if (in_fire && (in_operation == trld_pkg::OP_RUN)) begin
      rd_data_r <= tile_mem[run_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      oor_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && (in_operation == trld_pkg::OP_RUN)) begin
            if (in_run_word == '0) begin
              pos_r <= '0;  // end of frame
            end else if (run_cnt != '0) begin
              cnt_r       <= run_cnt;
              oor_r       <= run_oor;
              out_valid_r <= 1'b1;
              state_r     <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_fire) begin
            pos_r <= pos_r + trld_pkg::POS_W'(1);  // wraps 63 -> 0
            cnt_r <= cnt_r - trld_pkg::CNT_W'(1);
            if (cnt_r == trld_pkg::CNT_W'(1)) begin
              out_valid_r <= 1'b0;
              state_r     <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  // read data holds until the next run request, which cannot arrive while emitting
  assign tile_q = oor_r ? '0 : rd_data_r;

  assign out_valid    = out_valid_r;
  assign out_grid_row = pos_r[trld_pkg::POS_W-1:trld_pkg::AXIS_W];
  assign out_grid_col = pos_r[trld_pkg::AXIS_W-1:0];
  assign out_line0    = ~tile_q[ 7: 0];
  assign out_line1    = ~tile_q[15: 8];
  assign out_line2    = ~tile_q[23:16];
  assign out_line3    = ~tile_q[31:24];
  assign out_line4    = ~tile_q[39:32];
  assign out_line5    = ~tile_q[47:40];
  assign out_line6    = ~tile_q[55:48];
  assign out_line7    = ~tile_q[63:56];
  assign out_last     = (cnt_r == trld_pkg::CNT_W'(1));

endmodule

`default_nettype wire

[src/trld_checker.sv]
// Port-level checker for tile_run_length_frame_decoder_core, attached by bind.
// Depends on trld_pkg and tile_run_length_frame_decoder_core_macros.svh.
`default_nettype none
`include "tile_run_length_frame_decoder_core_macros.svh"

module trld_port_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        in_operation,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [trld_pkg::AXIS_W-1:0] out_grid_row,
  input wire logic [trld_pkg::AXIS_W-1:0] out_grid_col,
  input wire logic [trld_pkg::LINE_W-1:0] out_line0,
  input wire logic                        out_last
);

  // no new request is taken while a run is still being emitted
  `TRLD_ASSERT_NOW(a_busy_while_emit, out_valid, !in_ready)

  // a run of tiles only starts right after a run request was accepted
  `TRLD_ASSERT_NOW(a_emit_after_run, $rose(out_valid),
    $past(in_valid && in_ready && (in_operation == trld_pkg::OP_RUN)))

  // the last tile of a run closes the output
  `TRLD_ASSERT_NEXT(a_last_ends_run, out_valid && out_ready && out_last, !out_valid)

  // a stalled tile stays valid and keeps its grid position and first row byte
  `TRLD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
    out_valid && $stable(out_grid_row) && $stable(out_grid_col) && $stable(out_line0))

endmodule

bind tile_run_length_frame_decoder_core trld_port_checker u_trld_port_checker (.*);

`default_nettype wire
